// ----- hw/rtl/tlbl_pkg.sv -----
package tlbl_pkg;

	// Field widths fixed by the request and response words
	localparam int VPAGE_BITS  = 36;
	localparam int PPAGE_BITS  = 20;
	localparam int OFFSET_BITS = 12;
	localparam int PA_BITS     = 32;

	// Default line counts (each a power of two)
	localparam int INSTR_L1_LINES_DEF = 16;
	localparam int DATA_L1_LINES_DEF  = 16;
	localparam int L2_LINES_DEF       = 64;

	// Depth of the queue between front and back
	localparam int Q_DEPTH = 2;

	// Action codes of a request word
	localparam logic ACT_TRANSLATE = 1'b0;
	localparam logic ACT_FLUSH     = 1'b1;

	// Flush targets of a request word
	localparam logic [1:0] TGT_INSTR_L1 = 2'd0;
	localparam logic [1:0] TGT_DATA_L1  = 2'd1;
	localparam logic [1:0] TGT_L2       = 2'd2;

	typedef enum logic [2:0] {
		OP_TRANSLATE,
		OP_FLUSH_I,
		OP_FLUSH_D,
		OP_FLUSH_L2,
		OP_NOP
	} op_t;

	typedef enum logic {
		BK_IDLE,
		BK_EXEC
	} bk_state_t;

	typedef struct packed {
		logic                   action;
		logic [1:0]             flush_target;
		logic                   is_instruction;
		logic [VPAGE_BITS-1:0]  virtual_page;
		logic [OFFSET_BITS-1:0] byte_offset;
		logic [PPAGE_BITS-1:0]  walk_page;
		logic                   walk_ok;
	} req_t;

	typedef struct packed {
		logic               hit;
		logic [PA_BITS-1:0] phys_addr;
		logic               status;
	} rsp_t;

	// Classified word held in the queue
	typedef struct packed {
		op_t                    op;
		logic                   is_instruction;
		logic [VPAGE_BITS-1:0]  virtual_page;
		logic [OFFSET_BITS-1:0] byte_offset;
		logic [PPAGE_BITS-1:0]  walk_page;
		logic                   walk_ok;
	} q_word_t;

	// Build the physical address: page above the offset, low bits kept
	function automatic logic [PA_BITS-1:0] phys_of(logic [PPAGE_BITS-1:0] pp,
		logic [OFFSET_BITS-1:0] off);
		logic [63:0] wide;
		wide = 64'({pp, off});
		return wide[PA_BITS-1:0];
	endfunction

endpackage

// ----- hw/rtl/tlbl_front.sv -----
module tlbl_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  tlbl_pkg::req_t    req,
	output logic              q_valid,
	output tlbl_pkg::q_word_t q_word,
	input  logic              q_pop
);
	import tlbl_pkg::*;

	localparam int PTR_W = $clog2(Q_DEPTH);
	localparam int CNT_W = $clog2(Q_DEPTH + 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(Q_DEPTH);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(Q_DEPTH - 1);

	q_word_t          slot_q [Q_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	op_t              op;
	q_word_t          word;

	// Classify the incoming word
	always_comb begin
		op = OP_TRANSLATE;
		if (req.action == ACT_FLUSH) begin
			case (req.flush_target)
				TGT_INSTR_L1: op = OP_FLUSH_I;
				TGT_DATA_L1:  op = OP_FLUSH_D;
				TGT_L2:       op = OP_FLUSH_L2;
				default:      op = OP_NOP;
			endcase
		end
		word.op             = op;
		word.is_instruction = req.is_instruction;
		word.virtual_page   = req.virtual_page;
		word.byte_offset    = req.byte_offset;
		word.walk_page      = req.walk_page;
		word.walk_ok        = req.walk_ok;
	end

	assign req_stall = (count_q == CNT_FULL);
	assign push      = req_valid && !req_stall;
	assign q_valid   = (count_q != '0);
	assign q_word    = slot_q[rd_ptr_q];

	// Store pushed words
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= word;
		end
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (q_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !q_pop) begin
				count_q <= count_q + 1'b1;
			end else if (q_pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> count_q != '0)
		else $error("queue popped while empty");

	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !q_pop) |=> count_q == $past(count_q) + 1'b1)
		else $error("queue count did not advance on push");

	a_count_down: assert property (@(posedge clk) disable iff (!arst_n)
		(q_pop && !push) |=> count_q == $past(count_q) - 1'b1)
		else $error("queue count did not drop on pop");

endmodule

// ----- hw/rtl/tlbl_back.sv -----
module tlbl_back #(
	parameter int INSTR_L1_LINES = tlbl_pkg::INSTR_L1_LINES_DEF,
	parameter int DATA_L1_LINES  = tlbl_pkg::DATA_L1_LINES_DEF,
	parameter int L2_LINES       = tlbl_pkg::L2_LINES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	input  tlbl_pkg::q_word_t q_word,
	output logic              q_pop,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output tlbl_pkg::rsp_t    rsp
);
	import tlbl_pkg::*;

	localparam int IW_I  = $clog2(INSTR_L1_LINES);
	localparam int IW_D  = $clog2(DATA_L1_LINES);
	localparam int IW_L2 = $clog2(L2_LINES);
	localparam int TW_I  = VPAGE_BITS - IW_I;
	localparam int TW_D  = VPAGE_BITS - IW_D;
	localparam int TW_L2 = VPAGE_BITS - IW_L2;

	typedef struct packed {
		logic [TW_I-1:0]       tag;
		logic [PPAGE_BITS-1:0] ppage;
	} i_ent_t;

	typedef struct packed {
		logic [TW_D-1:0]       tag;
		logic [PPAGE_BITS-1:0] ppage;
	} d_ent_t;

	typedef struct packed {
		logic [TW_L2-1:0]      tag;
		logic [PPAGE_BITS-1:0] ppage;
	} l2_ent_t;

	// Tag and page stores, valid bits kept apart in flops
	i_ent_t  imem  [INSTR_L1_LINES];
	d_ent_t  dmem  [DATA_L1_LINES];
	l2_ent_t l2mem [L2_LINES];

	logic [INSTR_L1_LINES-1:0] iv_q;
	logic [DATA_L1_LINES-1:0]  dv_q;
	logic [L2_LINES-1:0]       l2v_q;

	bk_state_t state_q;
	bk_state_t state_d;

	q_word_t cur_s1;
	i_ent_t  i_rd_s1;
	d_ent_t  d_rd_s1;
	l2_ent_t l2_rd_s1;

	rsp_t rsp_q;
	logic rsp_valid_q;
	rsp_t res;
	logic exec;

	logic [IW_I-1:0]  idx_i;
	logic [IW_D-1:0]  idx_d;
	logic [IW_L2-1:0] idx_l2;
	logic             i_hit;
	logic             d_hit;
	logic             l2_hit;
	logic             mine_hit;
	logic             walk_fill;
	logic [PPAGE_BITS-1:0] mine_pp;
	logic [PPAGE_BITS-1:0] pp;
	logic [VPAGE_BITS-1:0] other_vp_i;
	logic [VPAGE_BITS-1:0] other_vp_d;
	logic             evict_i;
	logic             evict_d;
	logic             fill_i;
	logic             fill_d;
	logic             fill_l2;
	logic             drop_i;
	logic             drop_d;
	logic             flush_i;
	logic             flush_d;
	logic             flush_l2;

	// Sequence one word: read stores, then resolve and write back
	always_comb begin
		q_pop   = 1'b0;
		state_d = state_q;
		case (state_q)
			BK_IDLE: begin
				if (q_valid && (!rsp_valid_q || !rsp_stall)) begin
					q_pop   = 1'b1;
					state_d = BK_EXEC;
				end
			end
			BK_EXEC: state_d = BK_IDLE;
			default: state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Capture the word and read all three stores at its lines
	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_s1   <= q_word;
			i_rd_s1  <= imem[q_word.virtual_page[IW_I-1:0]];
			d_rd_s1  <= dmem[q_word.virtual_page[IW_D-1:0]];
			l2_rd_s1 <= l2mem[q_word.virtual_page[IW_L2-1:0]];
		end
	end

	assign exec   = (state_q == BK_EXEC);
	assign idx_i  = cur_s1.virtual_page[IW_I-1:0];
	assign idx_d  = cur_s1.virtual_page[IW_D-1:0];
	assign idx_l2 = cur_s1.virtual_page[IW_L2-1:0];

	// Compare tags and decide fills, drops and flushes
	always_comb begin
		i_hit    = iv_q[idx_i] && (i_rd_s1.tag == cur_s1.virtual_page[VPAGE_BITS-1:IW_I]);
		d_hit    = dv_q[idx_d] && (d_rd_s1.tag == cur_s1.virtual_page[VPAGE_BITS-1:IW_D]);
		l2_hit   = l2v_q[idx_l2]
			&& (l2_rd_s1.tag == cur_s1.virtual_page[VPAGE_BITS-1:IW_L2]);
		mine_hit = cur_s1.is_instruction ? i_hit : d_hit;
		mine_pp  = cur_s1.is_instruction ? i_rd_s1.ppage : d_rd_s1.ppage;

		// Rebuild the other L1 entry's page and match it to the evicted L2 tag
		other_vp_i = {i_rd_s1.tag, idx_i};
		other_vp_d = {d_rd_s1.tag, idx_d};
		evict_i    = l2v_q[idx_l2] && iv_q[idx_i]
			&& (other_vp_i[VPAGE_BITS-1:IW_L2] == l2_rd_s1.tag);
		evict_d    = l2v_q[idx_l2] && dv_q[idx_d]
			&& (other_vp_d[VPAGE_BITS-1:IW_L2] == l2_rd_s1.tag);

		walk_fill = 1'b0;
		fill_i    = 1'b0;
		fill_d    = 1'b0;
		fill_l2   = 1'b0;
		drop_i    = 1'b0;
		drop_d    = 1'b0;
		flush_i   = 1'b0;
		flush_d   = 1'b0;
		flush_l2  = 1'b0;
		pp        = mine_pp;
		res       = '0;

		if (exec) begin
			case (cur_s1.op)
				OP_TRANSLATE: begin
					if (mine_hit) begin
						pp      = mine_pp;
						res.hit = 1'b1;
					end else if (l2_hit) begin
						pp      = l2_rd_s1.ppage;
						res.hit = 1'b1;
						fill_i  = cur_s1.is_instruction;
						fill_d  = !cur_s1.is_instruction;
					end else if (!cur_s1.walk_ok) begin
						res.status = 1'b1;
					end else begin
						walk_fill = 1'b1;
						pp        = cur_s1.walk_page;
						fill_l2   = 1'b1;
						fill_i    = cur_s1.is_instruction;
						fill_d    = !cur_s1.is_instruction;
						drop_d    = cur_s1.is_instruction && evict_d;
						drop_i    = !cur_s1.is_instruction && evict_i;
					end
					if (mine_hit || l2_hit || walk_fill) begin
						res.phys_addr = phys_of(pp, cur_s1.byte_offset);
					end
				end
				OP_FLUSH_I:  flush_i  = 1'b1;
				OP_FLUSH_D:  flush_d  = 1'b1;
				OP_FLUSH_L2: flush_l2 = 1'b1;
				default: ;
			endcase
		end
	end

	// Write tag and page of filled lines
	always_ff @(posedge clk) begin
		if (fill_i) begin
			imem[idx_i] <= '{tag: cur_s1.virtual_page[VPAGE_BITS-1:IW_I], ppage: pp};
		end
		if (fill_d) begin
			dmem[idx_d] <= '{tag: cur_s1.virtual_page[VPAGE_BITS-1:IW_D], ppage: pp};
		end
		if (fill_l2) begin
			l2mem[idx_l2] <= '{tag: cur_s1.virtual_page[VPAGE_BITS-1:IW_L2], ppage: pp};
		end
	end

	// Update valid bits: flush whole store, set on fill, drop on eviction match
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iv_q  <= '0;
			dv_q  <= '0;
			l2v_q <= '0;
		end else begin
			if (flush_i) begin
				iv_q <= '0;
			end else if (fill_i) begin
				iv_q[idx_i] <= 1'b1;
			end else if (drop_i) begin
				iv_q[idx_i] <= 1'b0;
			end
			if (flush_d) begin
				dv_q <= '0;
			end else if (fill_d) begin
				dv_q[idx_d] <= 1'b1;
			end else if (drop_d) begin
				dv_q[idx_d] <= 1'b0;
			end
			if (flush_l2) begin
				l2v_q <= '0;
			end else if (fill_l2) begin
				l2v_q[idx_l2] <= 1'b1;
			end
		end
	end

	// Hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (exec) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (exec) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		exec |-> !rsp_valid_q)
		else $error("result produced while output register still full");

	a_pop_exec: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> exec && rsp_valid_q == 1'b0)
		else $error("popped word not executed next cycle");

	a_flush_l2: assert property (@(posedge clk) disable iff (!arst_n)
		flush_l2 |=> l2v_q == '0)
		else $error("L2 flush left valid lines");

	a_walk_fill: assert property (@(posedge clk) disable iff (!arst_n)
		fill_l2 |=> rsp_valid_q && !rsp_q.hit && !rsp_q.status)
		else $error("walk fill did not report a miss");

endmodule

// ----- hw/rtl/two_level_tlb_lookup_unit.sv -----
// Two-level TLB lookup: direct-mapped instruction L1, data L1 and shared L2, each
// line count a power of two. A request word either translates a virtual page
// (L1 chosen by is_instruction, then L2, then the page-walk answer carried in the
// word) or flushes one store (an unknown target flushes none); every request word
// yields exactly one response word. The front stage classifies words into a
// two-entry queue; the back stage takes one word at a time (store read, then
// compare and write-back), the next word's store read following this write-back.
// The response sits in an output register; the back stage starts the next word
// only while that register is empty or being taken, so a stalled response holds
// the back stage. Every entry reads as invalid right after reset, since the valid
// bits are flops cleared by reset and no clearing pass is needed; a flush takes
// effect in its own execute cycle.
module two_level_tlb_lookup_unit #(
	parameter int INSTR_L1_LINES = tlbl_pkg::INSTR_L1_LINES_DEF,
	parameter int DATA_L1_LINES  = tlbl_pkg::DATA_L1_LINES_DEF,
	parameter int L2_LINES       = tlbl_pkg::L2_LINES_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  tlbl_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output tlbl_pkg::rsp_t rsp
);
	import tlbl_pkg::*;

	logic    q_valid;
	logic    q_pop;
	q_word_t q_word;

	tlbl_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.q_valid   (q_valid),
		.q_word    (q_word),
		.q_pop     (q_pop)
	);

	tlbl_back #(
		.INSTR_L1_LINES (INSTR_L1_LINES),
		.DATA_L1_LINES  (DATA_L1_LINES),
		.L2_LINES       (L2_LINES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_word    (q_word),
		.q_pop     (q_pop),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule
